// ===== hw/rtl/tempo_pulse_multiplier_defines.svh =====
// Assertion macros shared by the tempo pulse multiplier RTL.
`ifndef TEMPO_PULSE_MULTIPLIER_DEFINES_SVH
`define TEMPO_PULSE_MULTIPLIER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpm_pkg.sv =====
// Package with the types, codes and constants of the tempo pulse multiplier.
package tpm_pkg;

    // Field widths of the transaction payloads.
    localparam int CMD_W      = 2;
    localparam int CTRL_W     = 12;
    localparam int SUB_W      = 32;
    localparam int MULT_W     = 6;
    localparam int TICK_BITS_DEF = 32;

    // Command codes carried in the input transaction.
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CTRL = 2'd2;

    // Multiplier value after reset.
    localparam logic [MULT_W-1:0] MULT_RESET = 6'd2;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CTRL_W-1:0] ctrl_value;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic             pulse_on;
        logic [SUB_W-1:0] sub_period;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // take the input transaction
        logic step;      // one divider iteration
        logic finish;    // commit the quotient to the state
        logic load_out;  // capture the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the offered transaction needs a division
    } t_stat;

    // Multiplier from the control sample: (value >> 8) * 2 + 2, range 2..32.
    function automatic logic [MULT_W-1:0] mult_from_ctrl(input logic [CTRL_W-1:0] v);
        return {1'b0, v[CTRL_W-1:8], 1'b0} + MULT_RESET;
    endfunction

endpackage

// ===== hw/rtl/tpm_ctrl.sv =====
// Controller state machine of the tempo pulse multiplier.
module tpm_ctrl
    import tpm_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int DIV_W = TICK_BITS + MULT_W;
    localparam int CNT_W = $clog2(DIV_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;

    // The output register can take a result when empty or being drained.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (i_stat.need_div) begin
                        n_state = S_DIV;
                        n_cnt   = '0;
                    end else begin
                        o_cmd.load_out = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid follows loads and drains of the output register.
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/tpm_dpath.sv =====
// Datapath of the tempo pulse multiplier: phase state, divider and output register.
module tpm_dpath
    import tpm_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_out  o_data
);

    localparam int DIV_W = TICK_BITS + MULT_W;

    // Architectural state.
    logic [TICK_BITS-1:0] r_rise, n_rise;
    logic [TICK_BITS-1:0] r_fall, n_fall;
    logic [TICK_BITS-1:0] r_phase, n_phase;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [MULT_W-1:0]    r_mult, n_mult;
    logic                 r_level, n_level;

    // Divider registers and the pending operation.
    logic [DIV_W-1:0]     r_quo;
    logic [MULT_W-1:0]    r_rem;
    logic [MULT_W-1:0]    r_div;
    logic [MULT_W-1:0]    r_nm;
    logic                 r_op_edge;

    // Output payload register.
    t_out                 r_out;

    logic [MULT_W-1:0]    nm;
    logic                 is_edge;
    logic                 is_ctrl;
    logic [TICK_BITS-1:0] phase_inc;
    logic [TICK_BITS-1:0] quo;
    logic [MULT_W:0]      trial;
    logic [MULT_W:0]      diff;
    logic                 q_bit;

    // Decode of the offered transaction.
    assign nm      = mult_from_ctrl(i_data.ctrl_value);
    assign is_edge = (i_data.cmd == CMD_EDGE);
    assign is_ctrl = (i_data.cmd == CMD_CTRL);
    assign o_stat.need_div = is_edge || (is_ctrl && (nm != r_mult));

    assign phase_inc = r_phase + 1'b1;
    assign quo       = r_quo[TICK_BITS-1:0];

    // One restoring division step: shift in the next dividend bit and subtract.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign q_bit = (trial >= {1'b0, r_div});

    // Next architectural state.
    always_comb begin
        n_rise  = r_rise;
        n_fall  = r_fall;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_mult  = r_mult;
        n_level = r_level;
        if (i_cmd.start && (i_data.cmd == CMD_TICK)) begin
            // Timer tick: advance the phase, wrap at the fall mark.
            if (r_phase >= r_fall) begin
                n_level = 1'b0;
                n_phase = '0;
            end else begin
                n_phase = phase_inc;
                if (phase_inc >= r_rise) begin
                    n_level = 1'b1;
                end
            end
            n_tick = r_tick + 1'b1;
        end else if (i_cmd.finish) begin
            n_rise = quo;
            n_fall = {quo[TICK_BITS-2:0], 1'b0};
            if (r_op_edge) begin
                n_level = 1'b1;
                n_phase = quo;
                n_tick  = '0;
            end else begin
                n_mult = r_nm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_phase <= '0;
            r_tick  <= '0;
            r_mult  <= MULT_RESET;
            r_level <= 1'b0;
        end else begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_mult  <= n_mult;
            r_level <= n_level;
        end
    end

    // Divider load and iteration; the edge divides the tick count, the control
    // update divides the rescaled sub-period.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && o_stat.need_div) begin
            r_op_edge <= is_edge;
            r_nm      <= nm;
            r_rem     <= '0;
            if (is_edge) begin
                r_quo <= DIV_W'(r_tick);
                r_div <= r_mult;
            end else begin
                r_quo <= DIV_W'(r_rise) * DIV_W'(r_mult);
                r_div <= nm;
            end
        end else if (i_cmd.step) begin
            r_rem <= q_bit ? diff[MULT_W-1:0] : trial[MULT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
        end
    end

    // Output register captures the state after the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.pulse_on   <= n_level;
            r_out.sub_period <= SUB_W'(n_rise);
        end
    end

    assign o_data = r_out;

endmodule

// ===== hw/rtl/tempo_pulse_multiplier.sv =====
// Top level of the tempo pulse multiplier.
//
// Each input transaction is a timer tick, a rising edge of the incoming clock,
// or a new multiplier control sample; each gives one result with the output
// level and the current sub-period in ticks. Ticks, unused codes and control
// samples that leave the multiplier unchanged need no division, and the next
// transaction can follow at once. A rising edge, or a control sample that
// changes the multiplier, runs a restoring divider one quotient bit per cycle
// over TICK_BITS + 6 bits, and no further transaction is accepted until the
// quotient is committed and its result captured. A new transaction is taken
// only while the output register is empty or is being drained in the same
// cycle, so a result that the receiver holds off also holds off the input
// until it is taken.
`include "tempo_pulse_multiplier_defines.svh"

module tempo_pulse_multiplier
    import tpm_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd  ctrl_cmd;
    t_stat dp_stat;

    tpm_ctrl #(
        .TICK_BITS (TICK_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (dp_stat),
        .o_cmd       (ctrl_cmd)
    );

    tpm_dpath #(
        .TICK_BITS (TICK_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (ctrl_cmd),
        .o_stat  (dp_stat),
        .o_data  (o_data)
    );

    // No new transaction is taken while the divider iterates.
    `TPM_ASSERT_NOW(a_no_start_in_div, ctrl_cmd.step, !ctrl_cmd.start && !o_ready,
        "transaction accepted during division")

    // A transaction that needs no division yields its result in the next cycle.
    `TPM_ASSERT_NEXT(a_direct_result, ctrl_cmd.start && !dp_stat.need_div, o_valid,
        "direct result not presented")

    // Committing a quotient always captures a result.
    `TPM_ASSERT_NOW(a_finish_loads, ctrl_cmd.finish, ctrl_cmd.load_out && !ctrl_cmd.step,
        "quotient committed without a result")

    // A rising edge drives the output on.
    `TPM_ASSERT_NEXT(a_edge_pulse_on, ctrl_cmd.finish && u_dpath.r_op_edge, o_data.pulse_on,
        "rising edge did not turn the output on")

endmodule
